// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// Season hysteresis selector package
// Shared types, widths, season codes and register indexes for the selector.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  // Field widths.
  localparam int unsigned TEMP_W     = 13;
  localparam int unsigned HYST_W     = 9;
  localparam int unsigned CMP_W      = 15;
  localparam int unsigned LOCK_W     = 16;
  localparam int unsigned LOCK_MS_W  = 26;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SEASON_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Milliseconds in one second.
  localparam logic [LOCK_MS_W-1:0] MS_PER_SECOND = LOCK_MS_W'(1000);

  typedef logic [SEASON_W-1:0] season_t;

  // Season codes.
  localparam season_t SEASON_SUMMER      = 2'd0;
  localparam season_t SEASON_SPRING_FALL = 2'd1;
  localparam season_t SEASON_WINTER      = 2'd2;
  localparam season_t SEASON_EXTREME     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EXTREME_START     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINTER_START      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_FALL_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_SUMMER       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_SPRING_FALL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_WINTER       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_EXTREME      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SECONDS   = 3'd7;

  // Thresholds and hysteresis values as seen by the classifier.
  typedef struct packed {
    logic signed [TEMP_W-1:0] extreme_start;
    logic signed [TEMP_W-1:0] winter_start;
    logic signed [TEMP_W-1:0] spring_fall_start;
    logic [HYST_W-1:0]        hyst_summer;
    logic [HYST_W-1:0]        hyst_spring_fall;
    logic [HYST_W-1:0]        hyst_winter;
    logic [HYST_W-1:0]        hyst_extreme;
  } thr_t;

endpackage

`default_nettype wire

// File: rtl/shs_classify.sv
// ----------------------------------------------------------------------------
// Season candidate classifier
// Works out the candidate season for one sample from the current season,
// the thresholds and their hysteresis bands.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_classify (
  input  wire shs_pkg::thr_t                        thr,
  input  wire                                       season_valid,
  input  wire shs_pkg::season_t                     season_cur,
  input  wire logic signed [shs_pkg::TEMP_W-1:0]    temperature,
  input  wire                                       sensor_valid,
  output shs_pkg::season_t                          season_cand
);

  logic signed [shs_pkg::CMP_W-1:0] t_x;
  logic signed [shs_pkg::CMP_W-1:0] ext_x;
  logic signed [shs_pkg::CMP_W-1:0] win_x;
  logic signed [shs_pkg::CMP_W-1:0] spf_x;
  logic signed [shs_pkg::CMP_W-1:0] spf_lo;
  logic signed [shs_pkg::CMP_W-1:0] spf_hi;
  logic signed [shs_pkg::CMP_W-1:0] win_lo;
  logic signed [shs_pkg::CMP_W-1:0] win_hi;
  logic signed [shs_pkg::CMP_W-1:0] ext_lo;
  logic signed [shs_pkg::CMP_W-1:0] ext_hi;
  shs_pkg::season_t                 direct;
  shs_pkg::season_t                 stepped;

  // Sign-extend everything to a width where the band edges cannot overflow.
  assign t_x   = shs_pkg::CMP_W'(temperature);
  assign ext_x = shs_pkg::CMP_W'(thr.extreme_start);
  assign win_x = shs_pkg::CMP_W'(thr.winter_start);
  assign spf_x = shs_pkg::CMP_W'(thr.spring_fall_start);

  // Hysteresis band edges.
  assign spf_lo = spf_x - $signed({6'd0, thr.hyst_spring_fall});
  assign spf_hi = spf_x + $signed({6'd0, thr.hyst_summer});
  assign win_lo = win_x - $signed({6'd0, thr.hyst_winter});
  assign win_hi = win_x + $signed({6'd0, thr.hyst_spring_fall});
  assign ext_lo = ext_x - $signed({6'd0, thr.hyst_extreme});
  assign ext_hi = ext_x + $signed({6'd0, thr.hyst_winter});

  // Direct classification, used for the very first sample.
  always_comb begin
    if (t_x <= ext_x) begin
      direct = shs_pkg::SEASON_EXTREME;
    end else if (t_x <= win_x) begin
      direct = shs_pkg::SEASON_WINTER;
    end else if (t_x <= spf_x) begin
      direct = shs_pkg::SEASON_SPRING_FALL;
    end else begin
      direct = shs_pkg::SEASON_SUMMER;
    end
  end

  // Step from the current season, honouring the hysteresis bands.
  always_comb begin
    case (season_cur)
      shs_pkg::SEASON_SUMMER: begin
        stepped = (t_x <= spf_lo) ? shs_pkg::SEASON_SPRING_FALL : shs_pkg::SEASON_SUMMER;
      end
      shs_pkg::SEASON_SPRING_FALL: begin
        if (t_x > spf_hi) begin
          stepped = shs_pkg::SEASON_SUMMER;
        end else if (t_x <= win_lo) begin
          stepped = shs_pkg::SEASON_WINTER;
        end else begin
          stepped = shs_pkg::SEASON_SPRING_FALL;
        end
      end
      shs_pkg::SEASON_WINTER: begin
        if (t_x > win_hi) begin
          stepped = shs_pkg::SEASON_SPRING_FALL;
        end else if (t_x <= ext_lo) begin
          stepped = shs_pkg::SEASON_EXTREME;
        end else begin
          stepped = shs_pkg::SEASON_WINTER;
        end
      end
      default: begin
        stepped = (t_x > ext_hi) ? shs_pkg::SEASON_WINTER : shs_pkg::SEASON_EXTREME;
      end
    endcase
  end

  // A bad sensor picks summer on the first sample and holds the season later.
  always_comb begin
    if (!season_valid) begin
      season_cand = sensor_valid ? direct : shs_pkg::SEASON_SUMMER;
    end else begin
      season_cand = sensor_valid ? stepped : season_cur;
    end
  end

endmodule

`default_nettype wire

// File: rtl/season_hysteresis_selector_core.sv
// ----------------------------------------------------------------------------
// Season hysteresis selector core
// An accepted input word passes the input register, then the result register.
// Throughput is one word per cycle while out_stall is low; the season and
// last-change time update as a word moves from the input register to the result
// register. Synchronous active-low reset clears the pipeline and the season state
// and loads the default thresholds; the first word after reset classifies directly.
// ----------------------------------------------------------------------------
`default_nettype none

module season_hysteresis_selector_core (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // Input channel.
  input  wire                                        in_valid,
  output logic                                       in_stall,
  input  wire logic signed [shs_pkg::TEMP_W-1:0]     in_temperature,
  input  wire                                        in_sensor_valid,
  input  wire logic [shs_pkg::TIME_W-1:0]            in_now_ms,
  // Result channel.
  output logic                                       out_valid,
  input  wire                                        out_stall,
  output logic [shs_pkg::SEASON_W-1:0]               out_active_season,
  output logic                                       out_season_changed,
  output logic                                       out_change_held,
  // Configuration port.
  input  wire                                        cfg_we,
  input  wire logic [shs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [shs_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // Configuration registers.
  shs_pkg::thr_t                        thr_r;
  logic [shs_pkg::LOCK_MS_W-1:0]        lock_ms_r;
  logic [shs_pkg::LOCK_MS_W-1:0]        lock_ms_nxt;

  // Input register.
  logic                                 v1_r;
  logic signed [shs_pkg::TEMP_W-1:0]    temp_r;
  logic                                 ok_r;
  logic [shs_pkg::TIME_W-1:0]           now_r;

  // Season state.
  logic                                 season_valid_r;
  shs_pkg::season_t                     season_r;
  shs_pkg::season_t                     season_nxt;
  logic [shs_pkg::TIME_W-1:0]           last_change_r;

  // Result register.
  logic                                 v2_r;
  shs_pkg::season_t                     res_season_r;
  logic                                 res_changed_r;
  logic                                 res_held_r;

  logic                                 in_accept;
  logic                                 advance;
  shs_pkg::season_t                     cand;
  logic [shs_pkg::TIME_W-1:0]           elapsed;
  logic                                 lock_active;
  logic                                 changed;
  logic                                 held;

  // Handshake: the result register frees up when its word is taken.
  assign advance   = v1_r && (!v2_r || !out_stall);
  assign in_stall  = v1_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Lockout length in milliseconds is worked out once, at the write.
  assign lock_ms_nxt = shs_pkg::LOCK_MS_W'(cfg_wdata) * shs_pkg::MS_PER_SECOND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.extreme_start     <= 13'sd0;
      thr_r.winter_start      <= 13'sd200;
      thr_r.spring_fall_start <= 13'sd500;
      thr_r.hyst_summer       <= 9'd20;
      thr_r.hyst_spring_fall  <= 9'd20;
      thr_r.hyst_winter       <= 9'd20;
      thr_r.hyst_extreme      <= 9'd20;
      lock_ms_r               <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        shs_pkg::CFG_EXTREME_START:     thr_r.extreme_start     <= cfg_wdata[12:0];
        shs_pkg::CFG_WINTER_START:      thr_r.winter_start      <= cfg_wdata[12:0];
        shs_pkg::CFG_SPRING_FALL_START: thr_r.spring_fall_start <= cfg_wdata[12:0];
        shs_pkg::CFG_HYST_SUMMER:       thr_r.hyst_summer       <= cfg_wdata[8:0];
        shs_pkg::CFG_HYST_SPRING_FALL:  thr_r.hyst_spring_fall  <= cfg_wdata[8:0];
        shs_pkg::CFG_HYST_WINTER:       thr_r.hyst_winter       <= cfg_wdata[8:0];
        shs_pkg::CFG_HYST_EXTREME:      thr_r.hyst_extreme      <= cfg_wdata[8:0];
        shs_pkg::CFG_LOCKOUT_SECONDS:   lock_ms_r               <= lock_ms_nxt;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_accept) begin
      v1_r <= 1'b1;
    end else if (advance) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      temp_r <= in_temperature;
      ok_r   <= in_sensor_valid;
      now_r  <= in_now_ms;
    end
  end

  // Candidate season.
  shs_classify u_classify (
    .thr          (thr_r),
    .season_valid (season_valid_r),
    .season_cur   (season_r),
    .temperature  (temp_r),
    .sensor_valid (ok_r),
    .season_cand  (cand)
  );

  // Lockout check with wrapping time.
  assign elapsed     = now_r - last_change_r;
  assign lock_active = (lock_ms_r != '0) &&
                       (elapsed < {{(shs_pkg::TIME_W-shs_pkg::LOCK_MS_W){1'b0}}, lock_ms_r});

  always_comb begin
    changed = 1'b0;
    held    = 1'b0;
    if (!season_valid_r) begin
      changed = 1'b1;
    end else if (cand != season_r) begin
      if (lock_active) begin
        held = 1'b1;
      end else begin
        changed = 1'b1;
      end
    end
  end

  assign season_nxt = changed ? cand : season_r;

  // Season state updates as the word moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      season_valid_r <= 1'b0;
      season_r       <= shs_pkg::SEASON_SUMMER;
      last_change_r  <= '0;
    end else if (advance) begin
      season_valid_r <= 1'b1;
      season_r       <= season_nxt;
      if (changed) begin
        last_change_r <= now_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= 1'b1;
    end else if (!out_stall) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_season_r  <= season_nxt;
      res_changed_r <= changed;
      res_held_r    <= held;
    end
  end

  assign out_valid          = v2_r;
  assign out_active_season  = res_season_r;
  assign out_season_changed = res_changed_r;
  assign out_change_held    = res_held_r;

  // A word never both changes the season and reports a held change.
  a_changed_or_held : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !(res_changed_r && res_held_r))
    else $error("result reports both a change and a held change");

  // Once a season is adopted it stays adopted until reset.
  a_season_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    season_valid_r |=> season_valid_r)
    else $error("season state lost without reset");

  // A change records the word's timestamp as the last change time.
  a_last_change : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && changed) |=> (last_change_r == $past(now_r)))
    else $error("last change time not taken from the changing word");

  // The result season always matches the season state it produced.
  a_result_state : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (res_season_r == season_r))
    else $error("result season differs from the stored season");

  // Input is only stalled while the input register holds a word.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

// File: tb/sv/shs_season_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Season selector scoreboard
// Keeps its own copy of the thresholds, the hysteresis values, the lockout and
// the season state. For every accepted input word it works out the result
// word that the selector must return, and checks result words in order.
// ----------------------------------------------------------------------------

package shs_season_scoreboard_pkg;
  import shs_pkg::*;

  typedef struct packed {
    season_t season;
    logic    changed;
    logic    held;
  } season_verdict_t;

  class season_scoreboard;
    // Register copies, held as plain integers (the lockout unsigned) so that the compares are exact.
    int                extreme_start;
    int                winter_start;
    int                spring_fall_start;
    int                hyst_summer;
    int                hyst_spring_fall;
    int                hyst_winter;
    int                hyst_extreme;
    int unsigned       lockout_s;
    // Season state as tracked from the accepted words.
    bit                season_known;
    season_t           season_now;
    logic [TIME_W-1:0] last_change_ms;
    season_verdict_t   pending_verdicts[$];
    int                mismatches;

    function new();
      extreme_start     = 0;
      winter_start      = 200;
      spring_fall_start = 500;
      hyst_summer       = 20;
      hyst_spring_fall  = 20;
      hyst_winter       = 20;
      hyst_extreme      = 20;
      lockout_s         = 0;
      season_known      = 1'b0;
      season_now        = SEASON_SUMMER;
      last_change_ms    = '0;
      mismatches        = 0;
    endfunction

    // Register writes keep only the low bits that each register holds.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_EXTREME_START:     extreme_start     = int'($signed(data[TEMP_W-1:0]));
        CFG_WINTER_START:      winter_start      = int'($signed(data[TEMP_W-1:0]));
        CFG_SPRING_FALL_START: spring_fall_start = int'($signed(data[TEMP_W-1:0]));
        CFG_HYST_SUMMER:       hyst_summer       = int'(data[HYST_W-1:0]);
        CFG_HYST_SPRING_FALL:  hyst_spring_fall  = int'(data[HYST_W-1:0]);
        CFG_HYST_WINTER:       hyst_winter       = int'(data[HYST_W-1:0]);
        CFG_HYST_EXTREME:      hyst_extreme      = int'(data[HYST_W-1:0]);
        CFG_LOCKOUT_SECONDS:   lockout_s         = int'(data[LOCK_W-1:0]);
        default: ;
      endcase
    endfunction

    // Direct classification, used for the first word after reset only.
    function season_t classify(int t);
      if (t <= extreme_start) return SEASON_EXTREME;
      if (t <= winter_start) return SEASON_WINTER;
      if (t <= spring_fall_start) return SEASON_SPRING_FALL;
      return SEASON_SUMMER;
    endfunction

    // Candidate season with hysteresis; each season moves one step at most.
    function season_t hysteresis_step(season_t cur, int t);
      case (cur)
        SEASON_SUMMER: begin
          if (t <= spring_fall_start - hyst_spring_fall) return SEASON_SPRING_FALL;
          return SEASON_SUMMER;
        end
        SEASON_SPRING_FALL: begin
          if (t > spring_fall_start + hyst_summer) return SEASON_SUMMER;
          if (t <= winter_start - hyst_winter) return SEASON_WINTER;
          return SEASON_SPRING_FALL;
        end
        SEASON_WINTER: begin
          if (t > winter_start + hyst_spring_fall) return SEASON_SPRING_FALL;
          if (t <= extreme_start - hyst_extreme) return SEASON_EXTREME;
          return SEASON_WINTER;
        end
        default: begin
          if (t > extreme_start + hyst_winter) return SEASON_WINTER;
          return SEASON_EXTREME;
        end
      endcase
    endfunction

    // Advance the season for one accepted word and queue the result it must give.
    function void note_sample(logic signed [TEMP_W-1:0] temp, logic ok,
                              logic [TIME_W-1:0] now);
      int                t;
      season_t           cand;
      season_verdict_t   v;
      logic [TIME_W-1:0] lock_ms;
      logic [TIME_W-1:0] elapsed;
      t         = int'(temp);
      v.changed = 1'b0;
      v.held    = 1'b0;
      if (!season_known) begin
        // The first word adopts its season at once, with no lockout test.
        season_now     = ok ? classify(t) : SEASON_SUMMER;
        season_known   = 1'b1;
        last_change_ms = now;
        v.changed      = 1'b1;
      end else begin
        cand = ok ? hysteresis_step(season_now, t) : season_now;
        if (cand != season_now) begin
          lock_ms = TIME_W'(lockout_s * 1000);
          elapsed = now - last_change_ms;
          if (lockout_s != 0 && elapsed < lock_ms) begin
            v.held = 1'b1;
          end else begin
            season_now     = cand;
            last_change_ms = now;
            v.changed      = 1'b1;
          end
        end
      end
      v.season = season_now;
      pending_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_verdict(season_t season, logic changed, logic held);
      season_verdict_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing pending: expected none, actual season %0d",
                 $time, season);
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("active_season", want.season, season);
      compare_field("season_changed", {1'b0, want.changed}, {1'b0, changed});
      compare_field("change_held", {1'b0, want.held}, {1'b0, held});
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_season_hysteresis_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Season hysteresis selector testbench
// Drives temperature words through the selector with random gaps and result
// back-pressure, including one long hold that fills the pipeline. A short
// directed sweep walks every season transition, the bad-sensor cases and the
// lockout edges, across the time wrap; random phases then vary every register
// between its extremes and aim most temperatures at the hysteresis edges.
// ----------------------------------------------------------------------------

module tb_season_hysteresis_selector_core;
  import shs_pkg::*;
  import shs_season_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 136;
  localparam int TEMP_MIN        = -4096;
  localparam int TEMP_MAX        = 4095;

  logic                     clk                = 1'b0;
  logic                     rst_n              = 1'b0;
  logic                     in_valid           = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_temperature     = '0;
  logic                     in_sensor_valid    = 1'b0;
  logic [TIME_W-1:0]        in_now_ms          = '0;
  logic                     out_valid;
  logic                     out_stall          = 1'b0;
  logic [SEASON_W-1:0]      out_active_season;
  logic                     out_season_changed;
  logic                     out_change_held;
  logic                     cfg_we             = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index          = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata          = '0;

  season_scoreboard         sb;
  int                       tx_mode            = 1;
  int                       rx_mode            = 1;
  bit                       hold_request       = 1'b0;
  int                       cycle_count        = 0;
  logic signed [TEMP_W-1:0] last_temp          = '0;
  logic [TIME_W-1:0]        clock_ms           = 32'hFFF0_0000;

  // Directed sweep through every transition at the default thresholds.
  int sweep_temps [16] = '{-4096, 4095, 480, 520, 521, 480, 100, 180,
                           220, -20, 20, 21, -4096, 221, 221, 4095};
  bit sweep_ok    [16] = '{0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};

  always #4 clk = ~clk;

  season_hysteresis_selector_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temperature     (in_temperature),
    .in_sensor_valid    (in_sensor_valid),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_active_season  (out_active_season),
    .out_season_changed (out_season_changed),
    .out_change_held    (out_change_held),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle cycles before a word: none, uniform, or mostly none with odd bursts.
  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return int'($urandom_range(0, 13));
      default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 13)) : 0;
    endcase
  endfunction

  // Offer one word and hold it steady until the selector takes it.
  task automatic send_word(logic signed [TEMP_W-1:0] temp, logic ok, logic [TIME_W-1:0] now);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_temperature  <= temp;
    in_sensor_valid <= ok;
    in_now_ms       <= now;
    do @(posedge clk); while (in_stall);
    sb.note_sample(temp, ok, now);
    last_temp = temp;
  endtask

  // One register write; the caller lowers the write enable after a group.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Stop offering words and wait for every outstanding result.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold on request, then check the word.
  initial begin
    int stall_cycles;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall_cycles = hold_request ? HOLD_CYCLES : draw_wait(rx_mode);
      hold_request = 1'b0;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_verdict(out_active_season, out_season_changed, out_change_held);
    end
  end

  // Main sequence.
  initial begin
    int                t;
    int                pick;
    int                lock_s;
    int                th [3];
    int                hy [4];
    logic [TIME_W-1:0] lock_base;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sweep. The first word has a bad sensor and a very cold
    // reading, so it must settle on summer rather than classify.
    for (int i = 0; i < 16; i++) begin
      send_word(TEMP_W'(sweep_temps[i]), sweep_ok[i], clock_ms);
      clock_ms = clock_ms + 100;
    end

    // Two-second lockout across the wrap of the millisecond clock.
    drain(4);
    write_reg(CFG_LOCKOUT_SECONDS, CFG_DATA_W'(2));
    cfg_we <= 1'b0;
    send_word(TEMP_W'(TEMP_MIN), 1'b1, 32'hFFFF_FC00);
    send_word(TEMP_W'(TEMP_MAX), 1'b1, 32'hFFFF_FC00 + 1999);
    send_word(TEMP_W'(TEMP_MAX), 1'b1, 32'hFFFF_FC00 + 2000);

    // Longest lockout: one millisecond short of it, then exactly on it.
    drain(4);
    write_reg(CFG_LOCKOUT_SECONDS, CFG_DATA_W'(65535));
    cfg_we <= 1'b0;
    lock_base = sb.last_change_ms;
    send_word(TEMP_W'(TEMP_MIN), 1'b1, lock_base + 65534999);
    send_word(TEMP_W'(TEMP_MIN), 1'b1, lock_base + 65535000);
    clock_ms = lock_base + 65535000;

    // Random phases, each with fresh register settings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain(6);

      // Thresholds: ordered, arbitrary (often out of order), extreme, or tight.
      case (ph % 4)
        0: begin
          th[0] = int'($urandom_range(0, 1800)) - 1000;
          th[1] = th[0] + int'($urandom_range(0, 800));
          th[2] = th[1] + int'($urandom_range(0, 900));
        end
        1: begin
          th[0] = int'($urandom_range(0, 8191)) + TEMP_MIN;
          th[1] = int'($urandom_range(0, 8191)) + TEMP_MIN;
          th[2] = int'($urandom_range(0, 8191)) + TEMP_MIN;
        end
        2: begin
          th[0] = TEMP_MIN;
          th[1] = (ph < 6) ? TEMP_MIN : TEMP_MAX;
          th[2] = TEMP_MAX;
        end
        default: begin
          th[0] = int'($urandom_range(0, 200)) - 100;
          th[1] = th[0] + int'($urandom_range(0, 30));
          th[2] = th[1] + int'($urandom_range(0, 30));
        end
      endcase

      // Hysteresis: wide random, all at one extreme, or small.
      for (int k = 0; k < 4; k++) begin
        case (ph % 3)
          0: hy[k] = int'($urandom_range(0, 511));
          1: hy[k] = (ph % 2 == 1) ? 511 : 0;
          default: hy[k] = int'($urandom_range(0, 40));
        endcase
      end

      // Lockout: off, a few seconds, the longest, or anything.
      case ((ph / 2) % 4)
        0: lock_s = 0;
        1: lock_s = int'($urandom_range(1, 5));
        2: lock_s = 65535;
        default: lock_s = int'($urandom_range(0, 65535));
      endcase

      // Unused high bits of the data word carry junk that must be ignored.
      write_reg(CFG_EXTREME_START,     {3'($urandom_range(0, 7)), TEMP_W'(th[0])});
      write_reg(CFG_WINTER_START,      {3'($urandom_range(0, 7)), TEMP_W'(th[1])});
      write_reg(CFG_SPRING_FALL_START, {3'($urandom_range(0, 7)), TEMP_W'(th[2])});
      write_reg(CFG_HYST_SUMMER,       {7'($urandom_range(0, 127)), HYST_W'(hy[0])});
      write_reg(CFG_HYST_SPRING_FALL,  {7'($urandom_range(0, 127)), HYST_W'(hy[1])});
      write_reg(CFG_HYST_WINTER,       {7'($urandom_range(0, 127)), HYST_W'(hy[2])});
      write_reg(CFG_HYST_EXTREME,      {7'($urandom_range(0, 127)), HYST_W'(hy[3])});
      write_reg(CFG_LOCKOUT_SECONDS,   CFG_DATA_W'(lock_s));
      cfg_we <= 1'b0;

      // Idle patterns differ per phase; one phase pushes words back to back
      // while the result side holds off, so the selector must stall its input.
      tx_mode = ph % 3;
      rx_mode = (ph + 1) % 3;
      if (ph == 2) begin
        tx_mode      = 0;
        hold_request = 1'b1;
      end

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Temperature: mostly on a hysteresis edge, else a drift or anything.
        pick = int'($urandom_range(0, 99));
        if (pick < 55) begin
          t = th[$urandom_range(0, 2)] + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1) == 1) t = t + hy[$urandom_range(0, 3)];
          else t = t - hy[$urandom_range(0, 3)];
        end else if (pick < 80) begin
          t = int'(last_temp) + int'($urandom_range(0, 100)) - 50;
        end else begin
          t = int'($urandom_range(0, 8191)) + TEMP_MIN;
        end

        // Time: steps on the scale of the lockout, its exact edge, or a jump.
        pick = int'($urandom_range(0, 99));
        if (pick < 8) begin
          clock_ms = $urandom;
        end else if (pick < 16 && lock_s != 0) begin
          clock_ms = sb.last_change_ms + TIME_W'(lock_s * 1000) - $urandom_range(0, 1);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, (lock_s == 0) ? 3000 : lock_s * 1000 / 3);
        end

        send_word(TEMP_W'(t), ($urandom_range(0, 99) < 88), clock_ms);
      end
    end

    drain(8);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
